@@ rtl/tna_pkg.sv @@
// Shared opcodes and constants for the triangle normal and area block.
package tna_pkg;

	typedef enum logic {
		OP_VERTEX = 1'b0,
		OP_FACET  = 1'b1
	} op_t;

	localparam int AREA_BITS = 34;
	localparam logic [AREA_BITS-1:0] AREA_MAX = 34'h3_FFFF_FFFF;
	localparam int NORM_BITS = 16;
	localparam logic [NORM_BITS-1:0] NORM_ONE = 16'd16384;

endpackage

@@ rtl/triangle_normal_area.sv @@
// Top level: vertex store front end, corner queue and normal/area back end.
// A vertex write goes straight into the store. A facet makes three store reads in the front end.
// The back end runs one facet at a time,
// sequencing one shared multiplier, a bit-serial square root and a bit-serial divider.
// arst_n clears all control state at once; store contents are undefined until written.
module triangle_normal_area #(
	parameter int VERTEX_COUNT = 4096,
	parameter int COORD_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               op,
	input  logic [11:0]        vertex_slot,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic [11:0]        corner_a,
	input  logic [11:0]        corner_b,
	input  logic [11:0]        corner_c,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [33:0]        twice_area,
	output logic               degenerate
);

	localparam int QW = 9 * COORD_BITS;

	logic          f_push;
	logic          f_full;
	logic [QW-1:0] f_data;
	logic          b_pop;
	logic          b_empty;
	logic [QW-1:0] b_data;

	tna_front #(
		.VERTEX_COUNT(VERTEX_COUNT),
		.COORD_BITS  (COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.vertex_slot(vertex_slot),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.corner_a   (corner_a),
		.corner_b   (corner_b),
		.corner_c   (corner_c),
		.q_push     (f_push),
		.q_full     (f_full),
		.q_data     (f_data)
	);

	tna_fifo #(
		.WIDTH(QW)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_push),
		.full  (f_full),
		.wdata (f_data),
		.pop   (b_pop),
		.empty (b_empty),
		.rdata (b_data)
	);

	tna_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (b_empty),
		.q_data    (b_data),
		.q_pop     (b_pop),
		.empty     (empty),
		.pop       (pop),
		.normal_x  (normal_x),
		.normal_y  (normal_y),
		.normal_z  (normal_z),
		.twice_area(twice_area),
		.degenerate(degenerate)
	);

endmodule

@@ rtl/tna_front.sv @@
// Front end: accepts beats, writes the vertex store and fetches facet corners.
module tna_front #(
	parameter int VERTEX_COUNT = 4096,
	parameter int COORD_BITS   = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic                    op,
	input  logic [11:0]             vertex_slot,
	input  logic signed [15:0]      pos_x,
	input  logic signed [15:0]      pos_y,
	input  logic signed [15:0]      pos_z,
	input  logic [11:0]             corner_a,
	input  logic [11:0]             corner_b,
	input  logic [11:0]             corner_c,
	output logic                    q_push,
	input  logic                    q_full,
	output logic [9*COORD_BITS-1:0] q_data
);

	localparam int AW = $clog2(VERTEX_COUNT);
	localparam int VW = 3 * COORD_BITS;

	typedef enum logic [1:0] {F_IDLE, F_B, F_C, F_PUSH} fstate_t;

	fstate_t         state_q;
	logic [11:0]     cb_q;
	logic [11:0]     cc_q;
	logic [VW-1:0]   va_q;
	logic [VW-1:0]   vb_q;
	logic [VW-1:0]   mem [VERTEX_COUNT];
	logic [VW-1:0]   rdata_q;
	logic            rd_ok_q;
	logic [VW-1:0]   rvert;
	logic            accept;
	logic            is_facet;
	logic            rd_en;
	logic [11:0]     rd_idx;
	logic            rd_ok;
	logic            wr_en;
	logic [VW-1:0]   wdata;

	assign full     = state_q != F_IDLE;
	assign accept   = push && !full;
	assign is_facet = tna_pkg::op_t'(op) == tna_pkg::OP_FACET;
	assign wr_en    = accept && !is_facet && (32'(vertex_slot) < 32'(VERTEX_COUNT));
	assign wdata    = {COORD_BITS'(pos_x), COORD_BITS'(pos_y), COORD_BITS'(pos_z)};

	always_comb begin
		rd_en  = 1'b0;
		rd_idx = corner_a;
		case (state_q)
			F_IDLE: begin
				rd_en  = accept && is_facet;
				rd_idx = corner_a;
			end
			F_B: begin
				rd_en  = 1'b1;
				rd_idx = cb_q;
			end
			F_C: begin
				rd_en  = 1'b1;
				rd_idx = cc_q;
			end
			default: begin
				rd_en  = 1'b0;
				rd_idx = corner_a;
			end
		endcase
	end

	assign rd_ok  = 32'(rd_idx) < 32'(VERTEX_COUNT);
	assign rvert  = rd_ok_q ? rdata_q : '0;
	assign q_push = (state_q == F_PUSH) && !q_full;
	assign q_data = {va_q, vb_q, rvert};

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[AW'(vertex_slot)] <= wdata;
		if (rd_en) begin
			rdata_q <= mem[AW'(rd_idx)];
			rd_ok_q <= rd_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept && is_facet) begin
						cb_q    <= corner_b;
						cc_q    <= corner_c;
						state_q <= F_B;
					end
				end
				F_B: begin
					va_q    <= rvert;
					state_q <= F_C;
				end
				F_C: begin
					vb_q    <= rvert;
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/tna_fifo.sv @@
// Two-entry queue between front and back end.
module tna_fifo #(
	parameter int WIDTH = 144
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push)
				wptr_q <= !wptr_q;
			if (do_pop)
				rptr_q <= !rptr_q;
			if (do_push && !do_pop)
				count_q <= count_q + 2'd1;
			else if (do_pop && !do_push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

@@ rtl/tna_back.sv @@
// Back end: cross product, length by square root, normal by division, result register.
module tna_back #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  logic [9*COORD_BITS-1:0] q_data,
	output logic                    q_pop,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [15:0]      normal_x,
	output logic signed [15:0]      normal_y,
	output logic signed [15:0]      normal_z,
	output logic [33:0]             twice_area,
	output logic                    degenerate
);

	localparam int C   = COORD_BITS;
	localparam int H   = C + 1;
	localparam int LW  = 2 * H;
	localparam int NW  = LW + 1;
	localparam int SW  = 4 * H;
	localparam int CW  = $clog2(LW);
	localparam int XW  = (LW > tna_pkg::AREA_BITS) ? LW : tna_pkg::AREA_BITS;

	typedef enum logic [2:0] {B_IDLE, B_CROSS, B_SQ, B_SQRT, B_DIV, B_DONE} bstate_t;

	bstate_t               state_q;
	logic signed [H-1:0]   e1_q [3];
	logic signed [H-1:0]   e2_q [3];
	logic signed [NW-1:0]  n_q [3];
	logic [2:0]            k_q;
	logic [1:0]            comp_q;
	logic [1:0]            part_q;
	logic [3:0]            st_q;
	logic [CW-1:0]         cnt_q;
	logic [SW-1:0]         acc_q;
	logic [SW-1:0]         s_q;
	logic [LW+1:0]         rem_q;
	logic [LW-1:0]         root_q;
	logic [LW:0]           r_q;
	logic [14:0]           quo_q;
	logic signed [15:0]    nrm_q [3];
	logic                  out_valid_q;
	logic signed [15:0]    nx_q;
	logic signed [15:0]    ny_q;
	logic signed [15:0]    nz_q;
	logic [33:0]           area_q;
	logic                  degen_q;

	logic signed [C-1:0]   vin [9];
	logic [H-1:0]          mul_a;
	logic [H-1:0]          mul_b;
	logic [LW-1:0]         prod;
	logic signed [H-1:0]   op_a;
	logic signed [H-1:0]   op_b;
	logic signed [NW-1:0]  sprod;
	logic [LW-1:0]         mag_n;
	logic [LW+1:0]         rem_in;
	logic [LW+1:0]         trial;
	logic                  sq_ge;
	logic [LW:0]           r_in;
	logic                  div_ge;
	logic [15:0]           quo_full;
	logic [15:0]           quo_rnd;
	logic [15:0]           quo_cap;
	logic [XW-1:0]         len_ext;
	logic [33:0]           len_sat;
	logic                  out_free;
	logic                  out_load;

	genvar gi;
	generate
		for (gi = 0; gi < 9; gi++) begin : g_unpack
			assign vin[gi] = q_data[(9-gi)*C-1 -: C];
		end
	endgenerate

	function automatic logic [H-1:0] mag_e(input logic signed [H-1:0] v);
		return v[H-1] ? H'(-v) : H'(v);
	endfunction

	always_comb begin
		op_a = e1_q[1];
		op_b = e2_q[2];
		case (k_q)
			3'd0: begin op_a = e1_q[1]; op_b = e2_q[2]; end
			3'd1: begin op_a = e1_q[2]; op_b = e2_q[1]; end
			3'd2: begin op_a = e1_q[2]; op_b = e2_q[0]; end
			3'd3: begin op_a = e1_q[0]; op_b = e2_q[2]; end
			3'd4: begin op_a = e1_q[0]; op_b = e2_q[1]; end
			3'd5: begin op_a = e1_q[1]; op_b = e2_q[0]; end
			default: begin op_a = e1_q[1]; op_b = e2_q[2]; end
		endcase
	end

	assign mag_n = n_q[comp_q][NW-1] ? LW'(-n_q[comp_q]) : LW'(n_q[comp_q]);

	always_comb begin
		mul_a = mag_e(op_a);
		mul_b = mag_e(op_b);
		if (state_q == B_SQ) begin
			case (part_q)
				2'd0: begin mul_a = mag_n[H-1:0];  mul_b = mag_n[H-1:0]; end
				2'd1: begin mul_a = mag_n[LW-1:H]; mul_b = mag_n[H-1:0]; end
				2'd2: begin mul_a = mag_n[LW-1:H]; mul_b = mag_n[LW-1:H]; end
				default: begin mul_a = mag_n[H-1:0]; mul_b = mag_n[H-1:0]; end
			endcase
		end
	end

	assign prod  = mul_a * mul_b;
	assign sprod = (op_a[H-1] ^ op_b[H-1]) ? -NW'(prod) : NW'(prod);

	assign rem_in = {rem_q[LW-1:0], s_q[SW-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign sq_ge  = rem_in >= trial;

	assign r_in     = (st_q == 4'd0) ? NW'(mag_n) : {r_q[LW-1:0], 1'b0};
	assign div_ge   = r_in >= {1'b0, root_q};
	assign quo_full = {quo_q, div_ge};
	assign quo_rnd  = 16'((17'(quo_full) + 17'd1) >> 1);
	assign quo_cap  = (quo_rnd > tna_pkg::NORM_ONE) ? tna_pkg::NORM_ONE : quo_rnd;

	assign len_ext = XW'(root_q);
	assign len_sat = (len_ext > XW'(tna_pkg::AREA_MAX)) ? tna_pkg::AREA_MAX : 34'(len_ext);

	assign out_free = !out_valid_q || pop;
	assign out_load = (state_q == B_DONE) && out_free;
	assign q_pop    = (state_q == B_IDLE) && !q_empty;

	assign empty      = !out_valid_q;
	assign normal_x   = nx_q;
	assign normal_y   = ny_q;
	assign normal_z   = nz_q;
	assign twice_area = area_q;
	assign degenerate = degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			comp_q      <= '0;
			part_q      <= '0;
			st_q        <= '0;
			cnt_q       <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (pop && out_valid_q)
				out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						for (int i = 0; i < 3; i++) begin
							e1_q[i] <= H'(vin[3+i]) - H'(vin[i]);
							e2_q[i] <= H'(vin[6+i]) - H'(vin[i]);
						end
						k_q     <= '0;
						state_q <= B_CROSS;
					end
				end
				B_CROSS: begin
					if (k_q[0])
						n_q[k_q[2:1]] <= n_q[k_q[2:1]] - sprod;
					else
						n_q[k_q[2:1]] <= sprod;
					k_q <= k_q + 3'd1;
					if (k_q == 3'd5) begin
						comp_q  <= '0;
						part_q  <= '0;
						acc_q   <= '0;
						state_q <= B_SQ;
					end
				end
				B_SQ: begin
					case (part_q)
						2'd0: acc_q <= acc_q + SW'(prod);
						2'd1: acc_q <= acc_q + (SW'(prod) << (H + 1));
						default: acc_q <= acc_q + (SW'(prod) << LW);
					endcase
					if (part_q == 2'd2) begin
						part_q <= '0;
						comp_q <= comp_q + 2'd1;
						if (comp_q == 2'd2) begin
							s_q     <= acc_q + (SW'(prod) << LW);
							rem_q   <= '0;
							root_q  <= '0;
							cnt_q   <= '0;
							state_q <= B_SQRT;
						end
					end else begin
						part_q <= part_q + 2'd1;
					end
				end
				B_SQRT: begin
					s_q    <= s_q << 2;
					rem_q  <= sq_ge ? rem_in - trial : rem_in;
					root_q <= {root_q[LW-2:0], sq_ge};
					cnt_q  <= cnt_q + CW'(1);
					if (cnt_q == CW'(LW - 1)) begin
						comp_q  <= '0;
						st_q    <= '0;
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					if (root_q == '0) begin
						for (int i = 0; i < 3; i++)
							nrm_q[i] <= '0;
						state_q <= B_DONE;
					end else begin
						r_q   <= div_ge ? r_in - NW'(root_q) : r_in;
						quo_q <= quo_full[14:0];
						st_q  <= st_q + 4'd1;
						if (st_q == 4'd15) begin
							nrm_q[comp_q] <= n_q[comp_q][NW-1] ? -$signed(quo_cap)
								: $signed(quo_cap);
							comp_q <= comp_q + 2'd1;
							if (comp_q == 2'd2)
								state_q <= B_DONE;
						end
					end
				end
				B_DONE: begin
					if (out_load) begin
						nx_q    <= nrm_q[0];
						ny_q    <= nrm_q[1];
						nz_q    <= nrm_q[2];
						area_q  <= len_sat;
						degen_q <= root_q == '0;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/tna_checker.sv @@
// Port-level checks for the triangle normal and area block, bound to the top level.
module tna_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y,
	input logic signed [15:0] normal_z,
	input logic [33:0]        twice_area,
	input logic               degenerate
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(normal_x) && $stable(normal_y)
			&& $stable(normal_z) && $stable(twice_area) && $stable(degenerate))
		else $error("result beat changed while stalled");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && degenerate |-> normal_x == 16'sd0 && normal_y == 16'sd0
			&& normal_z == 16'sd0 && twice_area == 34'd0)
		else $error("degenerate facet with nonzero result");

	a_area: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !degenerate |-> twice_area != 34'd0)
		else $error("zero length without degenerate flag");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> normal_x >= -16'sd16384 && normal_x <= 16'sd16384
			&& normal_y >= -16'sd16384 && normal_y <= 16'sd16384
			&& normal_z >= -16'sd16384 && normal_z <= 16'sd16384)
		else $error("normal component out of unit range");

endmodule

bind triangle_normal_area tna_checker u_tna_checker (.*);
